>>> src/ecghp_pkg.sv
// Shared types and constants for the ECG high-pass / lead-off ring block.
// No dependencies; imported by ecghp_filter and ecg_highpass_leadoff_ring.
package ecghp_pkg;

    // Field widths fixed by the item format
    localparam int RAW_W    = 12;
    localparam int SMP_W    = 12;
    localparam int CNT_W    = 7;
    localparam int ALPHA_W  = 16;
    localparam int STATE_W  = 24;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_HP_ALPHA      = 2'd0;
    localparam logic [1:0] REG_LO_PLUS_USED  = 2'd1;
    localparam logic [1:0] REG_LO_MINUS_USED = 2'd2;

    localparam logic [ALPHA_W-1:0] HP_ALPHA_RESET = 16'd65208;

    // Lead-off raw sample window
    localparam logic [RAW_W-1:0] OFF_LOW_LIMIT  = 12'd30;
    localparam logic [RAW_W-1:0] OFF_HIGH_LIMIT = 12'd4060;

    // Output clamp and filter state saturation
    localparam logic signed [SMP_W-1:0]   SMP_MAX   = 12'sd2047;
    localparam logic signed [SMP_W-1:0]   SMP_MIN   = -12'sd2048;
    localparam logic signed [STATE_W-1:0] STATE_MAX = 24'sd8388607;
    localparam logic signed [STATE_W-1:0] STATE_MIN = -24'sd8388608;

    // One result item
    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    leads_off;
        logic                    valid_res;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } res_t;

endpackage

>>> src/ecghp_filter.sv
// One-pole DC-blocking high-pass filter, four pipeline steps per sample.
// Holds the filter state (previous output Q.8, previous input). Uses ecghp_pkg.
module ecghp_filter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [ecghp_pkg::RAW_W-1:0]      x,
    input  logic [ecghp_pkg::ALPHA_W-1:0]    alpha,
    output logic                             done,
    output logic signed [ecghp_pkg::SMP_W-1:0] y_out
);
    import ecghp_pkg::*;

    localparam int D_W    = STATE_W + 2;
    localparam int PROD_W = D_W + ALPHA_W + 1;
    localparam int Q_W    = PROD_W - 16;

    logic signed [STATE_W-1:0] prev_out_reg;
    logic [RAW_W-1:0]          prev_in_reg;
    logic                      st1_reg, st2_reg, st3_reg, st4_reg;
    logic signed [D_W-1:0]     d_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [STATE_W-1:0] y_reg;

    logic signed [RAW_W:0]     diff;
    logic signed [D_W-1:0]     d_next;
    logic signed [PROD_W-1:0]  prod_adj;
    logic signed [Q_W-1:0]     q;
    logic signed [STATE_W-1:0] y_next;
    logic signed [STATE_W-1:0] y_adj;
    logic signed [STATE_W-9:0] o_wide;
    logic signed [SMP_W-1:0]   o_next;

    // d = prev_output + (x - prev_input) * 256
    assign diff   = $signed({1'b0, x}) - $signed({1'b0, prev_in_reg});
    assign d_next = {{2{prev_out_reg[STATE_W-1]}}, prev_out_reg}
                  + {{(D_W-RAW_W-9){diff[RAW_W]}}, diff, 8'b0};

    // (alpha * d) / 65536 toward zero, saturated to the Q.8 state range
    assign prod_adj = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(65535) : '0);
    assign q        = prod_adj[PROD_W-1:16];
    always_comb begin
        if (q > Q_W'(STATE_MAX)) begin
            y_next = STATE_MAX;
        end else if (q < Q_W'(STATE_MIN)) begin
            y_next = STATE_MIN;
        end else begin
            y_next = q[STATE_W-1:0];
        end
    end

    // y / 256 toward zero, clamped to the sample range
    assign y_adj  = y_reg + (y_reg[STATE_W-1] ? STATE_W'(255) : '0);
    assign o_wide = y_adj[STATE_W-1:8];
    always_comb begin
        if (o_wide > (STATE_W-8)'(SMP_MAX)) begin
            o_next = SMP_MAX;
        end else if (o_wide < (STATE_W-8)'(SMP_MIN)) begin
            o_next = SMP_MIN;
        end else begin
            o_next = o_wide[SMP_W-1:0];
        end
    end

    // Step control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg      <= 1'b0;
            st2_reg      <= 1'b0;
            st3_reg      <= 1'b0;
            st4_reg      <= 1'b0;
            prev_out_reg <= '0;
            prev_in_reg  <= '0;
        end else begin
            st1_reg <= start;
            st2_reg <= st1_reg;
            st3_reg <= st2_reg;
            st4_reg <= st3_reg;
            if (start) begin
                prev_in_reg <= x;
            end
            if (st3_reg) begin
                prev_out_reg <= y_next;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg <= d_next;
        end
        if (st1_reg) begin
            prod_reg <= $signed({1'b0, alpha}) * d_reg;
        end
        if (st3_reg) begin
            y_reg <= y_next;
        end
    end

    assign done  = st4_reg;
    assign y_out = o_next;

endmodule

>>> src/ecg_highpass_leadoff_ring.sv
// Top level: ECG high-pass filter with lead-off detection and a ring of samples.
// Uses ecghp_pkg and ecghp_filter.
//
// Input channel (s_*): one item is a command. cmd 0 takes raw_sample: the
// leads are judged off if a wired lead-off pin reads low or the sample is
// outside 30..4060; off stores zero, otherwise the filtered sample is stored.
// Either way one result item follows. cmd 1 reads up to max_count of the
// newest stored samples, oldest first, one result item each, last set on the
// final one; an empty read gives a single item with valid_res 0.
// Result channel (m_*) is fed from a two-entry output queue, so a finished
// item waits there while the sequencer goes on.
// Flow: a sample with leads off goes straight to push, a filtered sample first
// waits out the four filter steps (multiplier registered). A read of n samples
// streams one item per cycle while the queue has room, from a registered ring
// read port; the next command is taken the cycle after the last ring read.
// A read never overlaps a ring write, so no forwarding is needed.
// Receiver stall: the queue fills, ring reads and sample stores hold until
// room frees; nothing is dropped. Reset clears write and queue pointers,
// fill count, filter state and registers (hp_alpha 65208); ring data undefined.
// Config: APB-style, registers at byte addresses 0, 4, 8, pready always high.
module ecg_highpass_leadoff_ring #(
    parameter int RING_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [ecghp_pkg::RAW_W-1:0]         s_raw_sample,
    input  logic                                s_lo_plus_low,
    input  logic                                s_lo_minus_low,
    input  logic [ecghp_pkg::CNT_W-1:0]         s_max_count,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ecghp_pkg::SMP_W-1:0]  m_sample,
    output logic                                m_leads_off,
    output logic                                m_valid_res,
    output logic [ecghp_pkg::CNT_W-1:0]         m_count,
    output logic                                m_last
);
    import ecghp_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILT,
        ST_PUSH,
        ST_READ
    } state_t;

    // Configuration registers
    logic [ALPHA_W-1:0] hp_alpha_reg;
    logic               lo_plus_used_reg;
    logic               lo_minus_used_reg;
    logic               cfg_wr;

    // Sequencer state
    state_t             state_reg;
    logic [PTR_W-1:0]   wp_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [RAW_W-1:0]   last_raw_reg;
    res_t               pend_reg;
    logic               pend_wr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   rd_n_reg;
    logic               rd_off_reg;
    logic               inflight_reg;
    logic               rd_last_reg;

    // Ring memory
    logic [SMP_W-1:0]   ring_mem [RING_DEPTH];
    logic [SMP_W-1:0]   rd_data_reg;

    // Output queue
    res_t               q_mem [2];
    logic               q_wr_idx_reg;
    logic               q_rd_idx_reg;
    logic [1:0]         q_cnt_reg;

    logic               accept;
    logic [RAW_W-1:0]   judge_raw;
    logic               off;
    logic               filt_start;
    logic               filt_done;
    logic signed [SMP_W-1:0] filt_y;
    logic [CNT_W-1:0]   n;
    logic [SUM_W-1:0]   start_sum;
    logic [PTR_W-1:0]   start_ptr;
    logic [1:0]         occ;
    logic               pop;
    logic               room;
    logic               issue;
    logic               ring_we;
    logic               push;
    res_t               push_data;
    res_t               q_head;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_alpha_reg      <= HP_ALPHA_RESET;
            lo_plus_used_reg  <= 1'b0;
            lo_minus_used_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HP_ALPHA:      hp_alpha_reg      <= pwdata[ALPHA_W-1:0];
                REG_LO_PLUS_USED:  lo_plus_used_reg  <= pwdata[0];
                REG_LO_MINUS_USED: lo_minus_used_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HP_ALPHA:      prdata = {16'b0, hp_alpha_reg};
            REG_LO_PLUS_USED:  prdata = {31'b0, lo_plus_used_reg};
            REG_LO_MINUS_USED: prdata = {31'b0, lo_minus_used_reg};
            default:           prdata = '0;
        endcase
    end

    // Lead-off judgement: a sample uses its own raw value, a read the latest one
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign judge_raw = (s_cmd == CMD_SAMPLE) ? s_raw_sample : last_raw_reg;
    assign off       = (lo_plus_used_reg & s_lo_plus_low)
                     | (lo_minus_used_reg & s_lo_minus_low)
                     | (judge_raw < OFF_LOW_LIMIT) | (judge_raw > OFF_HIGH_LIMIT);
    assign filt_start = accept & (s_cmd == CMD_SAMPLE) & ~off;

    // Read length and oldest entry
    assign n         = (fill_reg < s_max_count) ? fill_reg : s_max_count;
    assign start_sum = SUM_W'(wp_reg) + SUM_W'(RING_DEPTH) - SUM_W'(n);
    assign start_ptr = (start_sum >= SUM_W'(RING_DEPTH))
                     ? PTR_W'(start_sum - SUM_W'(RING_DEPTH)) : PTR_W'(start_sum);

    // Queue room, counting the ring read in flight
    assign pop     = m_valid & m_ready;
    assign occ     = q_cnt_reg + {1'b0, inflight_reg};
    assign room    = (occ < 2'd2) | pop;
    assign issue   = (state_reg == ST_READ) & room;
    assign ring_we = (state_reg == ST_PUSH) & room & pend_wr_reg;

    ecghp_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (filt_start),
        .x       (s_raw_sample),
        .alpha   (hp_alpha_reg),
        .done    (filt_done),
        .y_out   (filt_y)
    );

    // Command sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            last_raw_reg <= '0;
            pend_wr_reg  <= 1'b0;
            inflight_reg <= 1'b0;
        end else begin
            inflight_reg <= issue;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_cmd == CMD_SAMPLE) begin
                            last_raw_reg <= s_raw_sample;
                            if (off) begin
                                pend_reg    <= '{sample: '0, leads_off: 1'b1,
                                                 valid_res: 1'b1, count: '0, last: 1'b1};
                                pend_wr_reg <= 1'b1;
                                state_reg   <= ST_PUSH;
                            end else begin
                                state_reg   <= ST_FILT;
                            end
                        end else if (n == '0) begin
                            pend_reg    <= '{sample: '0, leads_off: off,
                                             valid_res: 1'b0, count: '0, last: 1'b1};
                            pend_wr_reg <= 1'b0;
                            state_reg   <= ST_PUSH;
                        end else begin
                            rd_ptr_reg <= start_ptr;
                            rem_reg    <= n;
                            rd_n_reg   <= n;
                            rd_off_reg <= off;
                            state_reg  <= ST_READ;
                        end
                    end
                end
                ST_FILT: begin
                    if (filt_done) begin
                        pend_reg    <= '{sample: filt_y, leads_off: 1'b0,
                                         valid_res: 1'b1, count: '0, last: 1'b1};
                        pend_wr_reg <= 1'b1;
                        state_reg   <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (room) begin
                        state_reg <= ST_IDLE;
                        if (pend_wr_reg) begin
                            wp_reg <= (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                            if (fill_reg < CNT_W'(RING_DEPTH)) begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_READ: begin
                    if (room) begin
                        rd_ptr_reg  <= (rd_ptr_reg == PTR_W'(RING_DEPTH - 1))
                                     ? '0 : rd_ptr_reg + 1'b1;
                        rem_reg     <= rem_reg - 1'b1;
                        rd_last_reg <= (rem_reg == CNT_W'(1));
                        if (rem_reg == CNT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[wp_reg] <= pend_reg.sample;
        end
        if (issue) begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // Queue push: ring read return or a pending single result
    assign push = inflight_reg | ((state_reg == ST_PUSH) & room);
    always_comb begin
        if (inflight_reg) begin
            push_data = '{sample: rd_data_reg, leads_off: rd_off_reg, valid_res: 1'b1,
                          count: rd_n_reg, last: rd_last_reg};
        end else begin
            push_data = pend_reg;
        end
    end

    // Two-entry output queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_idx_reg <= 1'b0;
            q_rd_idx_reg <= 1'b0;
            q_cnt_reg    <= '0;
        end else begin
            if (push) begin
                q_wr_idx_reg <= ~q_wr_idx_reg;
            end
            if (pop) begin
                q_rd_idx_reg <= ~q_rd_idx_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[q_wr_idx_reg] <= push_data;
        end
    end

    assign q_head      = q_mem[q_rd_idx_reg];
    assign m_valid     = (q_cnt_reg != 2'd0);
    assign m_sample    = q_head.sample;
    assign m_leads_off = q_head.leads_off;
    assign m_valid_res = q_head.valid_res;
    assign m_count     = q_head.count;
    assign m_last      = q_head.last;

endmodule
